### hdl/pwws_pkg.sv
// types and constants shared by the wakeup selector and its cells
`timescale 1ns / 1ps

package pwws_pkg;

  localparam int PRIO_W  = 6;
  localparam int IDX_W   = 6;
  localparam int MASK_W  = 64;
  localparam int REQ_W   = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SET      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE_ALL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  thread;
    logic [REQ_W-1:0]  priority_req;
    logic [MASK_W-1:0] waiters;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  woken;
    logic              last;
  } out_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              all;
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
  } tok_t;

endpackage

### hdl/pwws_cell.sv
// one table cell: priority entry, waiter bit and token stage
`timescale 1ns / 1ps

module pwws_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      load,
  input  logic                      wait_in,
  input  logic                      wr_en,
  input  logic [pwws_pkg::PRIO_W-1:0] wr_prio,
  input  pwws_pkg::tok_t            tok_in,
  output pwws_pkg::tok_t            tok_out,
  output logic                      wait_bit,
  output logic                      emit
);

  logic [pwws_pkg::PRIO_W-1:0] prio;
  pwws_pkg::tok_t              tok_next;

  assign emit = tok_in.valid && tok_in.all && wait_bit;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.all && wait_bit &&
        (!tok_in.found || (prio < tok_in.prio))) begin
      tok_next.found = 1'b1;
      tok_next.prio  = prio;
      tok_next.idx   = pwws_pkg::IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prio     <= '0;
      wait_bit <= 1'b0;
      tok_out  <= '0;
    end else begin
      if (wr_en) begin
        prio <= wr_prio;
      end
      if (load) begin
        wait_bit <= wait_in;
      end else if (adv && emit) begin
        wait_bit <= 1'b0;
      end
      if (adv) begin
        tok_out <= tok_next;
      end
    end
  end

endmodule

### hdl/priority_waiter_wakeup_selector.sv
// top level: priority table as a chain of cells with a travelling scan token
//
//   channel | signals                      | transfer when
//   --------+------------------------------+----------------------
//   input   | in_valid, in_ready, in_data  | in_valid && in_ready
//   output  | out_valid, out_ready, out_data| out_valid && out_ready
//
// set_priority and empty masks answer from the input cycle straight into the
// output register, so they can follow one a cycle while the output is taken.
// unused commands give no result. a wake command sends a token through the
// THREADS cells, one cell a cycle unless a full output register stalls it,
// and the block takes no new command until the token has left the last cell.
// in_ready is low while a token travels or a result waits. reset clears the
// table and token.
`timescale 1ns / 1ps

module priority_waiter_wakeup_selector #(
  parameter int THREADS      = 64,
  parameter int MAX_PRIORITY = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pwws_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pwws_pkg::out_t   out_data
);

  pwws_pkg::tok_t             tok [THREADS+1];
  pwws_pkg::tok_t             tok_start;
  logic [THREADS-1:0]         wait_vec;
  logic [THREADS-1:0]         emit_vec;
  logic [THREADS-1:0]         wr_vec;
  logic [THREADS-1:0]         mask;
  logic                       busy;
  logic                       accept;
  logic                       out_full;
  logic                       any_emit;
  logic                       fin_one;
  logic                       stall;
  logic                       adv;
  logic                       range_err;
  logic                       set_ok;
  logic                       direct_load;
  logic                       chain_load;
  logic                       launch;
  pwws_pkg::out_t             direct_res;
  pwws_pkg::out_t             chain_res;
  logic [THREADS-1:0]         remaining;
  logic [pwws_pkg::IDX_W-1:0] emit_idx;

  assign mask      = in_data.waiters[THREADS-1:0];
  assign out_full  = out_valid && !out_ready;
  assign in_ready  = !busy && !out_full;
  assign accept    = in_valid && in_ready;
  assign range_err = in_data.priority_req > pwws_pkg::REQ_W'(MAX_PRIORITY);
  assign set_ok    = accept && (in_data.command == pwws_pkg::CMD_SET) && !range_err;

  assign any_emit  = |emit_vec;
  assign fin_one   = tok[THREADS].valid && !tok[THREADS].all;
  assign stall     = (any_emit || fin_one) && out_full;
  assign adv       = !stall;
  assign remaining = wait_vec & ~emit_vec;

  assign tok[0] = tok_start;

  for (genvar i = 0; i < THREADS; i++) begin : g_cell
    assign wr_vec[i] = set_ok && (in_data.thread == pwws_pkg::IDX_W'(i));
    pwws_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .load     (launch),
      .wait_in  (mask[i]),
      .wr_en    (wr_vec[i]),
      .wr_prio  (in_data.priority_req[pwws_pkg::PRIO_W-1:0]),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .wait_bit (wait_vec[i]),
      .emit     (emit_vec[i])
    );
  end

  always_comb begin
    emit_idx = '0;
    for (int i = 0; i < THREADS; i++) begin
      if (emit_vec[i]) begin
        emit_idx = pwws_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    direct_load = 1'b0;
    launch      = 1'b0;
    direct_res  = '{status: pwws_pkg::ST_OK, woken: '0, last: 1'b1};
    if (accept) begin
      unique case (in_data.command)
        pwws_pkg::CMD_SET: begin
          direct_load = 1'b1;
          if (range_err) begin
            direct_res.status = pwws_pkg::ST_RANGE;
          end
        end
        pwws_pkg::CMD_WAKE_ONE, pwws_pkg::CMD_WAKE_ALL: begin
          if (mask == '0) begin
            direct_load       = 1'b1;
            direct_res.status = pwws_pkg::ST_EMPTY;
          end else begin
            launch = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    chain_load = adv && (any_emit || fin_one);
    chain_res  = '{status: pwws_pkg::ST_OK, woken: '0, last: 1'b1};
    if (any_emit) begin
      chain_res.woken = emit_idx;
      chain_res.last  = (remaining == '0);
    end else begin
      chain_res.woken = tok[THREADS].idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      tok_start <= '0;
    end else begin
      if (launch) begin
        busy            <= 1'b1;
        tok_start.valid <= 1'b1;
        tok_start.all   <= (in_data.command == pwws_pkg::CMD_WAKE_ALL);
        tok_start.found <= 1'b0;
        tok_start.prio  <= '0;
        tok_start.idx   <= '0;
      end else begin
        if (adv) begin
          tok_start.valid <= 1'b0;
        end
        if (adv && tok[THREADS].valid) begin
          busy <= 1'b0;
        end
      end
      if (direct_load || chain_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      out_data <= direct_res;
    end else if (chain_load) begin
      out_data <= chain_res;
    end
  end

endmodule

### verif/tb.sv
// self-checking testbench for the priority waiter wakeup selector
`timescale 1ns / 1ps

module tb;

  localparam logic [pwws_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_THREADS    = 64;
  localparam int MAX_PRIO       = 63;
  localparam int HOLD_CYCLES    = 300;
  localparam int SCAN_SETTLE    = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pwws_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwws_pkg::out_t out_data;

  logic [pwws_pkg::PRIO_W-1:0] prio_shadow [NUM_THREADS];
  pwws_pkg::out_t pending_results [$];

  int fail_cnt = 0;
  int shown = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_go_q = 1'b0;
  logic rx_calm = 1'b1;
  bit tx_calm = 1'b1;

  priority_waiter_wakeup_selector uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // append one expected result
  function automatic void queue_result(pwws_pkg::out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // expected results of one accepted command, updates the shadow table
  function automatic void compute_wakeups(pwws_pkg::in_t it);
    pwws_pkg::out_t r;
    logic [pwws_pkg::MASK_W-1:0] m;
    logic [pwws_pkg::PRIO_W-1:0] best_p;
    logic [pwws_pkg::IDX_W-1:0] best_i;
    bit found;
    m = it.waiters;
    r = '0;
    best_p = '0;
    best_i = '0;
    found = 1'b0;
    case (it.command)
      pwws_pkg::CMD_SET: begin
        if (it.priority_req > MAX_PRIO) begin
          r.status = pwws_pkg::ST_RANGE;
        end else begin
          prio_shadow[it.thread] = it.priority_req[pwws_pkg::PRIO_W-1:0];
          r.status = pwws_pkg::ST_OK;
        end
        r.last = 1'b1;
        queue_result(r);
      end
      pwws_pkg::CMD_WAKE_ONE: begin
        if (m == '0) begin
          r.status = pwws_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < NUM_THREADS; i++) begin
            if (m[i] && (!found || prio_shadow[i] < best_p)) begin
              found = 1'b1;
              best_p = prio_shadow[i];
              best_i = pwws_pkg::IDX_W'(i);
            end
          end
          r.status = pwws_pkg::ST_OK;
          r.woken = best_i;
        end
        r.last = 1'b1;
        queue_result(r);
      end
      pwws_pkg::CMD_WAKE_ALL: begin
        if (m == '0) begin
          r.status = pwws_pkg::ST_EMPTY;
          r.last = 1'b1;
          queue_result(r);
        end else begin
          for (int i = 0; i < NUM_THREADS; i++) begin
            if (m[i]) begin
              r.status = pwws_pkg::ST_OK;
              r.woken = pwws_pkg::IDX_W'(i);
              r.last = ((m >> (i + 1)) == '0);
              queue_result(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic pwws_pkg::in_t mk(logic [pwws_pkg::CMD_W-1:0] cmd, int thr, int prio,
                                       logic [pwws_pkg::MASK_W-1:0] m);
    pwws_pkg::in_t it;
    it.command = cmd;
    it.thread = pwws_pkg::IDX_W'(thr);
    it.priority_req = pwws_pkg::REQ_W'(prio);
    it.waiters = m;
    return it;
  endfunction

  function automatic logic [pwws_pkg::MASK_W-1:0] rand_mask();
    logic [pwws_pkg::MASK_W-1:0] m;
    int n;
    m = '0;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = 64'd1 << $urandom_range(0, 63);
      2, 3, 4: begin
        n = $urandom_range(1, 4);
        repeat (n) m |= 64'd1 << $urandom_range(0, 63);
      end
      5: m = '1;
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  function automatic pwws_pkg::in_t rand_item();
    pwws_pkg::in_t it;
    int pick;
    it.thread = pwws_pkg::IDX_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 15) it.priority_req = pwws_pkg::REQ_W'($urandom_range(64, 255));
    else if (pick < 55) it.priority_req = pwws_pkg::REQ_W'($urandom_range(0, 3));
    else it.priority_req = pwws_pkg::REQ_W'($urandom_range(0, 63));
    it.waiters = rand_mask();
    pick = $urandom_range(0, 99);
    if (pick < 40) it.command = pwws_pkg::CMD_SET;
    else if (pick < 70) it.command = pwws_pkg::CMD_WAKE_ONE;
    else if (pick < 95) it.command = pwws_pkg::CMD_WAKE_ALL;
    else it.command = CMD_UNUSED;
    return it;
  endfunction

  // offer one command and hold it until the transfer
  task automatic send_item(pwws_pkg::in_t it);
    if (!tx_calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 70)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    compute_wakeups(it);
  endtask

  // sender pause until every expected result is back, then let a scan finish
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic test_set_priority();
    send_item(mk(pwws_pkg::CMD_SET, 0, 0, '0));
    send_item(mk(pwws_pkg::CMD_SET, 63, 63, '0));
    send_item(mk(pwws_pkg::CMD_SET, 1, 64, '0));
    send_item(mk(pwws_pkg::CMD_SET, 2, 255, '1));
    send_item(mk(pwws_pkg::CMD_SET, 3, 63, '1));
    send_item(mk(pwws_pkg::CMD_SET, 62, 1, 64'h5555_5555_5555_5555));
    send_item(mk(pwws_pkg::CMD_SET, 10, 42, '0));
    wait_quiet();
  endtask

  task automatic test_wake_one();
    send_item(mk(pwws_pkg::CMD_WAKE_ONE, 63, 255, '0));
    send_item(mk(pwws_pkg::CMD_WAKE_ONE, 0, 0, '1));
    send_item(mk(pwws_pkg::CMD_WAKE_ONE, 0, 0, 64'h8000_0000_0000_0000));
    send_item(mk(pwws_pkg::CMD_WAKE_ONE, 0, 0, 64'hC000_0000_0000_0000));
    send_item(mk(pwws_pkg::CMD_WAKE_ONE, 0, 0, 64'h8000_0000_0000_0008));
    wait_quiet();
  endtask

  task automatic test_wake_all();
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, '0));
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, 64'h1));
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, 64'h8000_0000_0000_0000));
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 63, 255, '1));
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, 64'h8000_0000_0000_0001));
    send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA));
    wait_quiet();
  endtask

  task automatic test_unused_command();
    send_item(mk(CMD_UNUSED, 63, 255, '1));
    send_item(mk(pwws_pkg::CMD_SET, 5, 7, '0));
    send_item(mk(CMD_UNUSED, 0, 0, '0));
    wait_quiet();
  endtask

  task automatic test_receiver_holdoff();
    hold_go <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0: send_item(mk(pwws_pkg::CMD_SET, $urandom_range(0, 63), $urandom_range(0, 63), '0));
        1: send_item(mk(pwws_pkg::CMD_WAKE_ONE, 0, 0, {$urandom, $urandom}));
        default: send_item(mk(pwws_pkg::CMD_WAKE_ALL, 0, 0, 64'd1 << $urandom_range(0, 63)));
      endcase
    end
    hold_go <= 1'b0;
    wait_quiet();
  endtask

  task automatic test_random_traffic(int n, bit calm);
    tx_calm = calm;
    rx_calm <= calm;
    for (int i = 0; i < n; i++) send_item(rand_item());
    wait_quiet();
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin
    hold_go_q <= hold_go;
    if (hold_go && !hold_go_q) begin
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    pwws_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected transfer: status %0d woken %0d last %0d",
                   out_data.status, out_data.woken, out_data.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.woken !== want.woken ||
            out_data.last !== want.last) begin
          fail_cnt++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected status %0d woken %0d last %0d, got %0d %0d %0d",
                     want.status, want.woken, want.last,
                     out_data.status, out_data.woken, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_THREADS; i++) prio_shadow[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_set_priority();
    test_wake_one();
    test_wake_all();
    test_unused_command();
    test_receiver_holdoff();
    test_random_traffic(100, 1'b1);
    test_random_traffic(290, 1'b0);
    rx_calm <= 1'b1;
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
